// ===== rtl/mrpt_pkg.sv =====
// Shared types and constants for the Miller-Rabin prime test block.
// No dependencies; mrpt_front, mrpt_back and the top level import this package.
`default_nettype none

package mrpt_pkg;

    // Number of fixed witness bases and their storage widths
    localparam int BASE_COUNT = 7;
    localparam int BASE_W     = 5;
    localparam int IDX_W      = 3;

    // Classification that travels with each queued item
    typedef struct packed {
        logic trivial;   // verdict is already known, no base testing needed
        logic verdict;   // verdict for a trivial item
    } kind_t;

    // Witness base table: 2, 3, 5, 7, 11, 13, 17
    function automatic logic [BASE_W-1:0] base_of(input logic [IDX_W-1:0] idx);
        logic [BASE_W-1:0] b;
        case (idx)
            3'd0:    b = 5'd2;
            3'd1:    b = 5'd3;
            3'd2:    b = 5'd5;
            3'd3:    b = 5'd7;
            3'd4:    b = 5'd11;
            3'd5:    b = 5'd13;
            3'd6:    b = 5'd17;
            default: b = 5'd2;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mrpt_front.sv =====
// Front end: accepts a candidate, sorts out trivial cases and splits n-1
// into odd part and power of two, one bit per cycle. Depends on mrpt_pkg.
`default_nettype none

module mrpt_front #(
    parameter int WIDTH = 32,
    parameter int SW    = 5
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire  [WIDTH-1:0]     s_candidate,
    output logic                 push,
    input  wire                  full,
    output logic [WIDTH-1:0]     push_n,
    output logic [WIDTH-1:0]     push_d,
    output logic [SW-1:0]        push_s,
    output mrpt_pkg::kind_t      push_kind
);
    import mrpt_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SHIFT = 2'd1;
    localparam logic [1:0] ST_PUSH  = 2'd2;

    logic [1:0]       state_reg;
    logic [WIDTH-1:0] n_reg;
    logic [WIDTH-1:0] d_reg;
    logic [SW-1:0]    s_reg;
    kind_t            kind_reg;
    kind_t            kind_next;

    assign s_ready   = (state_reg == ST_IDLE);
    assign push      = (state_reg == ST_PUSH) && !full;
    assign push_n    = n_reg;
    assign push_d    = d_reg;
    assign push_s    = s_reg;
    assign push_kind = kind_reg;

    // Classify the incoming candidate
    always_comb begin
        kind_next = '{trivial: 1'b0, verdict: 1'b0};
        if (s_candidate[WIDTH-1:1] == '0) begin
            kind_next = '{trivial: 1'b1, verdict: 1'b0};
        end else if (s_candidate == WIDTH'(2)) begin
            kind_next = '{trivial: 1'b1, verdict: 1'b1};
        end else if (!s_candidate[0]) begin
            kind_next = '{trivial: 1'b1, verdict: 1'b0};
        end
    end

    // Capture, strip factors of two, hand over to the queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        n_reg     <= s_candidate;
                        d_reg     <= s_candidate - WIDTH'(1);
                        s_reg     <= '0;
                        kind_reg  <= kind_next;
                        state_reg <= kind_next.trivial ? ST_PUSH : ST_SHIFT;
                    end
                end
                ST_SHIFT: begin
                    if (d_reg[0]) begin
                        state_reg <= ST_PUSH;
                    end else begin
                        d_reg <= d_reg >> 1;
                        s_reg <= s_reg + SW'(1);
                    end
                end
                ST_PUSH: begin
                    if (!full) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mrpt_fifo.sv =====
// Two-entry queue between front end and back end.
// Depends on nothing but its data width parameter.
`default_nettype none

module mrpt_fifo #(
    parameter int DW = 8
) (
    input  wire           aclk,
    input  wire           aresetn,
    input  wire           push,
    input  wire  [DW-1:0] wdata,
    output logic          full,
    input  wire           pop,
    output logic [DW-1:0] rdata,
    output logic          empty
);
    logic [DW-1:0] mem_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign rdata = mem_reg[rd_ptr_reg];

    // Store on push
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)      count_reg <= count_reg + 2'd1;
            else if (pop && !push) count_reg <= count_reg - 2'd1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mrpt_mulmod.sv =====
// Bit-serial modular multiplier: p = a * b mod m, one bit of b per cycle.
// Requires a < m. Depends on nothing but its width parameter.
`default_nettype none

module mrpt_mulmod #(
    parameter int WIDTH = 32
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              start,
    input  wire  [WIDTH-1:0] a,
    input  wire  [WIDTH-1:0] b,
    input  wire  [WIDTH-1:0] m,
    output logic             busy,
    output logic             done,
    output logic [WIDTH-1:0] p
);
    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] r_reg;
    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] b_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [WIDTH+1:0] t;
    logic [WIDTH+1:0] m1;
    logic [WIDTH+1:0] m2;
    logic [WIDTH+1:0] r_next;

    assign busy = busy_reg;
    assign done = done_reg;
    assign p    = r_reg;

    // Double, add the multiplicand, fold back below m
    always_comb begin
        m1 = {2'b00, m};
        m2 = {1'b0, m, 1'b0};
        t  = {1'b0, r_reg, 1'b0} + (b_reg[WIDTH-1] ? {2'b00, a_reg} : '0);
        if (t >= m2)      r_next = t - m2;
        else if (t >= m1) r_next = t - m1;
        else              r_next = t;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                r_reg    <= '0;
                a_reg    <= a;
                b_reg    <= b;
                cnt_reg  <= CW'(WIDTH);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                r_reg   <= r_next[WIDTH-1:0];
                b_reg   <= b_reg << 1;
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mrpt_back.sv =====
// Back end: runs the witness rounds for one queued item on the single
// modular multiplier and holds the verdict register. Depends on mrpt_pkg.
`default_nettype none

module mrpt_back #(
    parameter int WIDTH     = 32,
    parameter int SW        = 5,
    parameter int NUM_BASES = 7
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    output logic                 pop,
    input  wire                  empty,
    input  wire  [WIDTH-1:0]     q_n,
    input  wire  [WIDTH-1:0]     q_d,
    input  wire  [SW-1:0]        q_s,
    input  mrpt_pkg::kind_t      q_kind,
    output logic                 mm_start,
    output logic [WIDTH-1:0]     mm_a,
    output logic [WIDTH-1:0]     mm_b,
    output logic [WIDTH-1:0]     mm_m,
    input  wire                  mm_done,
    input  wire  [WIDTH-1:0]     mm_p,
    output logic                 m_valid,
    input  wire                  m_ready,
    output logic                 m_is_prime
);
    import mrpt_pkg::*;

    localparam int BW = $clog2(WIDTH);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_BASE    = 3'd1;
    localparam logic [2:0] ST_EXP_SQ  = 3'd2;
    localparam logic [2:0] ST_EXP_MUL = 3'd3;
    localparam logic [2:0] ST_SQ_CHK  = 3'd4;
    localparam logic [2:0] ST_SQ_WAIT = 3'd5;
    localparam logic [2:0] ST_DONE    = 3'd6;

    logic [2:0]       state_reg;
    logic [WIDTH-1:0] n_reg;
    logic [WIDTH-1:0] d_reg;
    logic [SW-1:0]    s_reg;
    logic [SW-1:0]    j_reg;
    logic [BW-1:0]    bit_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [WIDTH-1:0] x_reg;
    logic             verdict_reg;
    logic             start_reg;
    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] b_reg;
    logic             m_valid_reg;
    logic             m_is_prime_reg;
    logic [WIDTH-1:0] base_w;
    logic [WIDTH-1:0] one_w;

    assign pop        = (state_reg == ST_IDLE) && !empty;
    assign mm_start   = start_reg;
    assign mm_a       = a_reg;
    assign mm_b       = b_reg;
    assign mm_m       = n_reg;
    assign m_valid    = m_valid_reg;
    assign m_is_prime = m_is_prime_reg;
    assign base_w     = WIDTH'(base_of(idx_reg));
    assign one_w      = WIDTH'(1);

    // Sequence: x = base^d by square-and-multiply, then s squarings
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            start_reg <= 1'b0;
            // Drop the output once taken, unless a new verdict replaces it
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (!empty) begin
                        n_reg       <= q_n;
                        d_reg       <= q_d;
                        s_reg       <= q_s;
                        idx_reg     <= '0;
                        verdict_reg <= q_kind.verdict;
                        state_reg   <= q_kind.trivial ? ST_DONE : ST_BASE;
                    end
                end
                ST_BASE: begin
                    if (idx_reg == IDX_W'(NUM_BASES) || n_reg == base_w) begin
                        verdict_reg <= 1'b1;
                        state_reg   <= ST_DONE;
                    end else begin
                        x_reg     <= one_w;
                        bit_reg   <= BW'(WIDTH - 1);
                        start_reg <= 1'b1;
                        a_reg     <= one_w;
                        b_reg     <= one_w;
                        state_reg <= ST_EXP_SQ;
                    end
                end
                ST_EXP_SQ: begin
                    if (mm_done) begin
                        x_reg <= mm_p;
                        if (d_reg[bit_reg]) begin
                            start_reg <= 1'b1;
                            a_reg     <= mm_p;
                            b_reg     <= base_w;
                            state_reg <= ST_EXP_MUL;
                        end else if (bit_reg == '0) begin
                            j_reg     <= '0;
                            state_reg <= ST_SQ_CHK;
                        end else begin
                            bit_reg   <= bit_reg - BW'(1);
                            start_reg <= 1'b1;
                            a_reg     <= mm_p;
                            b_reg     <= mm_p;
                        end
                    end
                end
                ST_EXP_MUL: begin
                    if (mm_done) begin
                        x_reg <= mm_p;
                        if (bit_reg == '0) begin
                            j_reg     <= '0;
                            state_reg <= ST_SQ_CHK;
                        end else begin
                            bit_reg   <= bit_reg - BW'(1);
                            start_reg <= 1'b1;
                            a_reg     <= mm_p;
                            b_reg     <= mm_p;
                            state_reg <= ST_EXP_SQ;
                        end
                    end
                end
                ST_SQ_CHK: begin
                    if (j_reg == s_reg) begin
                        if (x_reg != one_w) begin
                            verdict_reg <= 1'b0;
                            state_reg   <= ST_DONE;
                        end else begin
                            idx_reg   <= idx_reg + IDX_W'(1);
                            state_reg <= ST_BASE;
                        end
                    end else begin
                        start_reg <= 1'b1;
                        a_reg     <= x_reg;
                        b_reg     <= x_reg;
                        state_reg <= ST_SQ_WAIT;
                    end
                end
                ST_SQ_WAIT: begin
                    if (mm_done) begin
                        // Nontrivial square root of one marks a composite
                        if (mm_p == one_w && x_reg != one_w &&
                            x_reg != n_reg - one_w) begin
                            verdict_reg <= 1'b0;
                            state_reg   <= ST_DONE;
                        end else begin
                            x_reg     <= mm_p;
                            j_reg     <= j_reg + SW'(1);
                            state_reg <= ST_SQ_CHK;
                        end
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg    <= 1'b1;
                        m_is_prime_reg <= verdict_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/miller_rabin_prime_test_top.sv =====
// Miller-Rabin prime test, deterministic with witness bases 2 through 17.
// Channels: s_valid/s_ready/s_candidate in, m_valid/m_ready/m_is_prime out;
// one verdict for every candidate, in order of arrival.
// The front end takes a candidate when idle, flags 0, 1, 2 and even values
// at once and strips factors of two from n-1 at one bit per cycle, then
// passes the item through a two-entry queue to the back end.
// The back end runs each base on one bit-serial modular multiplier. A base
// costs at most WIDTH + s squarings plus one product per set bit of the
// odd part d; trivial candidates skip the multiplier.
// The front end can take and prepare the next candidate while the back end
// still works, so throughput is set by the back end's multiplier.
// The verdict sits in an output register; when the receiver stalls, the
// back end holds its next verdict and the queue and front end fill up.
// Reset (aresetn low, synchronous) empties the queue and drops any item.
// Depends on mrpt_pkg, mrpt_front, mrpt_fifo, mrpt_mulmod and mrpt_back.
`default_nettype none

module miller_rabin_prime_test_top #(
    parameter int WIDTH     = 32,
    parameter int NUM_BASES = 7
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_valid,
    output logic             s_ready,
    input  wire  [WIDTH-1:0] s_candidate,
    output logic             m_valid,
    input  wire              m_ready,
    output logic             m_is_prime
);
    import mrpt_pkg::*;

    localparam int SW = $clog2(WIDTH);
    localparam int DW = 2 * WIDTH + SW + $bits(kind_t);

    logic             push;
    logic             full;
    logic [WIDTH-1:0] push_n;
    logic [WIDTH-1:0] push_d;
    logic [SW-1:0]    push_s;
    kind_t            push_kind;
    logic             pop;
    logic             empty;
    logic [DW-1:0]    q_rdata;
    logic [WIDTH-1:0] q_n;
    logic [WIDTH-1:0] q_d;
    logic [SW-1:0]    q_s;
    kind_t            q_kind;
    logic             mm_start;
    logic [WIDTH-1:0] mm_a;
    logic [WIDTH-1:0] mm_b;
    logic [WIDTH-1:0] mm_m;
    logic             mm_busy;
    logic             mm_done;
    logic [WIDTH-1:0] mm_p;

    assign {q_kind, q_s, q_d, q_n} = q_rdata;

    mrpt_front #(.WIDTH(WIDTH), .SW(SW)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_candidate (s_candidate),
        .push        (push),
        .full        (full),
        .push_n      (push_n),
        .push_d      (push_d),
        .push_s      (push_s),
        .push_kind   (push_kind)
    );

    mrpt_fifo #(.DW(DW)) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wdata   ({push_kind, push_s, push_d, push_n}),
        .full    (full),
        .pop     (pop),
        .rdata   (q_rdata),
        .empty   (empty)
    );

    mrpt_mulmod #(.WIDTH(WIDTH)) u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mm_start),
        .a       (mm_a),
        .b       (mm_b),
        .m       (mm_m),
        .busy    (mm_busy),
        .done    (mm_done),
        .p       (mm_p)
    );

    mrpt_back #(.WIDTH(WIDTH), .SW(SW), .NUM_BASES(NUM_BASES)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop        (pop),
        .empty      (empty),
        .q_n        (q_n),
        .q_d        (q_d),
        .q_s        (q_s),
        .q_kind     (q_kind),
        .mm_start   (mm_start),
        .mm_a       (mm_a),
        .mm_b       (mm_b),
        .mm_m       (mm_m),
        .mm_done    (mm_done),
        .mm_p       (mm_p),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_is_prime (m_is_prime)
    );

    // Queue never overflows or underflows
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("pop from empty queue");

    // Multiplier is only started when free, and finishes before restart
    a_mm_free: assert property (@(posedge aclk) disable iff (!aresetn)
        mm_start |-> !mm_busy && !mm_done)
        else $error("multiplier started while busy");

    a_mm_done: assert property (@(posedge aclk) disable iff (!aresetn)
        mm_done |-> $past(mm_busy))
        else $error("multiplier done without running");

endmodule

`default_nettype wire
